// ===== hdl/dct_pkg.sv =====
// Shared types, constants and helpers for the distance constraint pipeline.
package dct_pkg;

    localparam int FRAC_W                  = 16;
    localparam int SQRT_STEPS              = 33;
    localparam int JAC_QUOT_W              = 17;
    localparam int JDOT_QUOT_W             = 32;
    localparam int COORDS_PER_BODY_DEFAULT = 2;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    // item data carried alongside the square root
    typedef struct packed {
        logic [9:0]         row;
        logic [10:0]        col_a;
        logic [10:0]        col_b;
        logic [30:0]        rest;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dvx;
        logic signed [32:0] dvy;
    } meta_t;

    // pass-through results once the distance is known
    typedef struct packed {
        logic [9:0]         row;
        logic [10:0]        col_a;
        logic [10:0]        col_b;
        logic signed [31:0] value;
        logic               coin;
    } pass_t;

    typedef struct packed {
        pass_t              p;
        logic               neg;
        logic signed [32:0] dvx;
        logic signed [32:0] dvy;
        logic [32:0]        d;
    } jside_t;

    typedef struct packed {
        pass_t              p;
        logic signed [31:0] rate;
        logic signed [17:0] jx;
        logic signed [17:0] jy;
        logic               ovf;
        logic               neg;
    } dside_t;

    typedef struct packed {
        logic ovf;
        logic neg;
    } yside_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'(SAT_MAX))
            r = SAT_MAX;
        else if (v < 64'(SAT_MIN))
            r = SAT_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== hdl/distance_constraint_terms.sv =====
// Top level: pipelined two-body distance constraint value, rate and Jacobian terms.
//
//  channel   | handshake         | payload
//  ----------+-------------------+-------------------------------------------------
//  item in   | start / busy      | row_index, first/second_index, rest_length,
//            |                   | positions and velocities of both bodies
//  result    | done (one cycle)  | row_out, columns, constraint_value/rate,
//            |                   | jac_x/y, jacdot_x/y, coincident
//
// One transfer per cycle enters; results leave in the order that the items entered.
// The depth is set by the 33-stage square root and the 17- and 32-stage
// dividers, one bit per stage; multiplies get a stage each.
// busy is always low: the receiver takes every result, so nothing stalls.
// Reset (rst_n, asynchronous) clears only the valid bits in flight.
module distance_constraint_terms #(
    parameter int COORDS_PER_BODY = dct_pkg::COORDS_PER_BODY_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [9:0]         row_index,
    input  logic [9:0]         first_index,
    input  logic [9:0]         second_index,
    input  logic [30:0]        rest_length,
    input  logic signed [31:0] first_pos_x,
    input  logic signed [31:0] first_pos_y,
    input  logic signed [31:0] second_pos_x,
    input  logic signed [31:0] second_pos_y,
    input  logic signed [31:0] first_vel_x,
    input  logic signed [31:0] first_vel_y,
    input  logic signed [31:0] second_vel_x,
    input  logic signed [31:0] second_vel_y,
    output logic               done,
    output logic [9:0]         row_out,
    output logic [10:0]        first_column,
    output logic [10:0]        second_column,
    output logic signed [31:0] constraint_value,
    output logic signed [31:0] constraint_rate,
    output logic signed [17:0] jac_x,
    output logic signed [17:0] jac_y,
    output logic signed [31:0] jacdot_x,
    output logic signed [31:0] jacdot_y,
    output logic               coincident
);

    import dct_pkg::*;

    localparam int NUM_J = 33 + FRAC_W;   // |dx| << 16
    localparam int NUM_D = 40 + FRAC_W;   // |e| << 16

    assign busy = 1'b0;

    // ---------------- stage 1: differences ----------------
    logic  s1_v_reg;
    meta_t s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else
            s1_v_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_reg.row   <= row_index;
        s1_reg.col_a <= 11'({1'b0, first_index} * 11'(COORDS_PER_BODY));
        s1_reg.col_b <= 11'({1'b0, second_index} * 11'(COORDS_PER_BODY));
        s1_reg.rest  <= rest_length;
        s1_reg.dx    <= 33'(second_pos_x) - 33'(first_pos_x);
        s1_reg.dy    <= 33'(second_pos_y) - 33'(first_pos_y);
        s1_reg.dvx   <= 33'(second_vel_x) - 33'(first_vel_x);
        s1_reg.dvy   <= 33'(second_vel_y) - 33'(first_vel_y);
    end

    // ---------------- stage 2: squares of the magnitudes ----------------
    logic [31:0] mx, my;
    logic        s2_v_reg;
    meta_t       s2_reg;
    logic [63:0] sqx_reg, sqy_reg;

    assign mx = s1_reg.dx[32] ? 32'(-s1_reg.dx) : s1_reg.dx[31:0];
    assign my = s1_reg.dy[32] ? 32'(-s1_reg.dy) : s1_reg.dy[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_reg  <= s1_reg;
        sqx_reg <= 64'(mx) * 64'(mx);
        sqy_reg <= 64'(my) * 64'(my);
    end

    // ---------------- stage 3: sum of squares ----------------
    logic        s3_v_reg;
    meta_t       s3_reg;
    logic [65:0] sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else
            s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_reg  <= s2_reg;
        sum_reg <= 66'(sqx_reg) + 66'(sqy_reg);
    end

    // ---------------- square root, one result bit per stage ----------------
    logic        sq_v_reg    [SQRT_STEPS];
    logic [35:0] sq_rem_reg  [SQRT_STEPS];
    logic [32:0] sq_root_reg [SQRT_STEPS];
    logic [65:0] sq_sum_reg  [SQRT_STEPS];
    meta_t       sq_meta_reg [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam int K = SQRT_STEPS - 1 - j;
        logic        v_in;
        logic [35:0] rem_in;
        logic [32:0] root_in;
        logic [65:0] sum_in;
        meta_t       meta_in;
        logic [35:0] rem_sh;
        logic [35:0] trial;
        logic        ge;

        if (j == 0) begin : g_first
            assign v_in    = s3_v_reg;
            assign rem_in  = '0;
            assign root_in = '0;
            assign sum_in  = sum_reg;
            assign meta_in = s3_reg;
        end else begin : g_next
            assign v_in    = sq_v_reg[j-1];
            assign rem_in  = sq_rem_reg[j-1];
            assign root_in = sq_root_reg[j-1];
            assign sum_in  = sq_sum_reg[j-1];
            assign meta_in = sq_meta_reg[j-1];
        end

        assign rem_sh = {rem_in[33:0], sum_in[2*K+1:2*K]};
        assign trial  = 36'({root_in, 2'b01});
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[j] <= 1'b0;
            else
                sq_v_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            sq_rem_reg[j]  <= ge ? rem_sh - trial : rem_sh;
            sq_root_reg[j] <= {root_in[31:0], ge};
            sq_sum_reg[j]  <= sum_in;
            sq_meta_reg[j] <= meta_in;
        end
    end

    // ---------------- stage P: value, coincidence, divider operands ----------------
    meta_t              sq_out;
    logic [32:0]        root_d;
    logic signed [33:0] diff;
    logic               p_v_reg;
    jside_t             p_side_reg;
    yside_t             p_yside_reg;
    logic [NUM_J-1:0]   p_nx_reg, p_ny_reg;

    assign sq_out = sq_meta_reg[SQRT_STEPS-1];
    assign root_d = sq_root_reg[SQRT_STEPS-1];
    assign diff   = $signed({1'b0, root_d}) - $signed({3'b000, sq_out.rest});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_v_reg <= 1'b0;
        else
            p_v_reg <= sq_v_reg[SQRT_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        p_side_reg.p.row   <= sq_out.row;
        p_side_reg.p.col_a <= sq_out.col_a;
        p_side_reg.p.col_b <= sq_out.col_b;
        p_side_reg.p.value <= sat32(64'(diff));
        p_side_reg.p.coin  <= (root_d == '0);
        p_side_reg.neg     <= sq_out.dx[32];
        p_side_reg.dvx     <= sq_out.dvx;
        p_side_reg.dvy     <= sq_out.dvy;
        p_side_reg.d       <= root_d;
        p_yside_reg.neg    <= sq_out.dy[32];
        p_yside_reg.ovf    <= 1'b0;
        p_nx_reg <= NUM_J'(sq_out.dx[32] ? -sq_out.dx : sq_out.dx) << FRAC_W;
        p_ny_reg <= NUM_J'(sq_out.dy[32] ? -sq_out.dy : sq_out.dy) << FRAC_W;
    end

    // ---------------- Jacobian dividers ----------------
    logic                  jdx_v, jdy_v;
    logic [JAC_QUOT_W-1:0] jqx, jqy;
    jside_t                jx_side;
    yside_t                jy_side;

    dct_div_pipe #(
        .NUM_W (NUM_J),
        .DEN_W (33),
        .QUOT_W(JAC_QUOT_W),
        .SIDE_W($bits(jside_t))
    ) u_jac_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (p_v_reg),
        .num      (p_nx_reg),
        .den      (p_side_reg.d),
        .in_side  (p_side_reg),
        .out_valid(jdx_v),
        .quot     (jqx),
        .out_side (jx_side)
    );

    dct_div_pipe #(
        .NUM_W (NUM_J),
        .DEN_W (33),
        .QUOT_W(JAC_QUOT_W),
        .SIDE_W($bits(yside_t))
    ) u_jac_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (p_v_reg),
        .num      (p_ny_reg),
        .den      (p_side_reg.d),
        .in_side  (p_yside_reg),
        .out_valid(jdy_v),
        .quot     (jqy),
        .out_side (jy_side)
    );

    // ---------------- stage J: signed Jacobian ----------------
    logic               j_v_reg;
    jside_t             j_side_reg;
    logic signed [17:0] j_jx_reg, j_jy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            j_v_reg <= 1'b0;
        else
            j_v_reg <= jdx_v;
    end

    always_ff @(posedge clk)
    begin
        j_side_reg <= jx_side;
        j_jx_reg   <= jx_side.neg ? -$signed(18'(jqx)) : $signed(18'(jqx));
        j_jy_reg   <= jy_side.neg ? -$signed(18'(jqy)) : $signed(18'(jqy));
    end

    // ---------------- stage M1: jac * dv products ----------------
    logic               m1_v_reg;
    jside_t             m1_side_reg;
    logic signed [17:0] m1_jx_reg, m1_jy_reg;
    logic signed [50:0] m1_px_reg, m1_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_v_reg <= 1'b0;
        else
            m1_v_reg <= j_v_reg;
    end

    always_ff @(posedge clk)
    begin
        m1_side_reg <= j_side_reg;
        m1_jx_reg   <= j_jx_reg;
        m1_jy_reg   <= j_jy_reg;
        m1_px_reg   <= 51'(j_jx_reg) * 51'(j_side_reg.dvx);
        m1_py_reg   <= 51'(j_jy_reg) * 51'(j_side_reg.dvy);
    end

    // ---------------- stage M2: dot product ----------------
    logic               m2_v_reg;
    jside_t             m2_side_reg;
    logic signed [17:0] m2_jx_reg, m2_jy_reg;
    logic signed [51:0] m2_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m2_v_reg <= 1'b0;
        else
            m2_v_reg <= m1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        m2_side_reg <= m1_side_reg;
        m2_jx_reg   <= m1_jx_reg;
        m2_jy_reg   <= m1_jy_reg;
        m2_sum_reg  <= 52'(m1_px_reg) + 52'(m1_py_reg);
    end

    // ---------------- stage R: rate, truncated toward zero ----------------
    logic signed [51:0] rate_rnd;
    logic               r_v_reg;
    jside_t             r_side_reg;
    logic signed [17:0] r_jx_reg, r_jy_reg;
    logic signed [35:0] r_full_reg;
    logic signed [31:0] r_rate_reg;

    assign rate_rnd = m2_sum_reg + (m2_sum_reg[51] ? 52'sd65535 : 52'sd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r_v_reg <= 1'b0;
        else
            r_v_reg <= m2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        r_side_reg <= m2_side_reg;
        r_jx_reg   <= m2_jx_reg;
        r_jy_reg   <= m2_jy_reg;
        r_full_reg <= rate_rnd[51:16];
        r_rate_reg <= sat32(64'($signed(rate_rnd[51:16])));
    end

    // ---------------- stage M3: rate * jac ----------------
    logic               m3_v_reg;
    jside_t             m3_side_reg;
    logic signed [17:0] m3_jx_reg, m3_jy_reg;
    logic signed [31:0] m3_rate_reg;
    logic signed [53:0] m3_tx_reg, m3_ty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m3_v_reg <= 1'b0;
        else
            m3_v_reg <= r_v_reg;
    end

    always_ff @(posedge clk)
    begin
        m3_side_reg <= r_side_reg;
        m3_jx_reg   <= r_jx_reg;
        m3_jy_reg   <= r_jy_reg;
        m3_rate_reg <= r_rate_reg;
        m3_tx_reg   <= 54'(r_full_reg) * 54'(r_jx_reg);
        m3_ty_reg   <= 54'(r_full_reg) * 54'(r_jy_reg);
    end

    // ---------------- stage E: dv minus the projected part ----------------
    logic signed [53:0] tx_rnd, ty_rnd;
    logic               e_v_reg;
    jside_t             e_side_reg;
    logic signed [17:0] e_jx_reg, e_jy_reg;
    logic signed [31:0] e_rate_reg;
    logic signed [39:0] e_ex_reg, e_ey_reg;

    assign tx_rnd = m3_tx_reg + (m3_tx_reg[53] ? 54'sd65535 : 54'sd0);
    assign ty_rnd = m3_ty_reg + (m3_ty_reg[53] ? 54'sd65535 : 54'sd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_v_reg <= 1'b0;
        else
            e_v_reg <= m3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        e_side_reg <= m3_side_reg;
        e_jx_reg   <= m3_jx_reg;
        e_jy_reg   <= m3_jy_reg;
        e_rate_reg <= m3_rate_reg;
        e_ex_reg   <= 40'(m3_side_reg.dvx) - 40'($signed(tx_rnd[53:16]));
        e_ey_reg   <= 40'(m3_side_reg.dvy) - 40'($signed(ty_rnd[53:16]));
    end

    // ---------------- stage N: magnitudes and overflow check ----------------
    logic [NUM_D-1:0] ex_num, ey_num;
    logic [64:0]      d_lim;
    logic             n_v_reg;
    dside_t           n_side_reg;
    yside_t           n_yside_reg;
    logic [NUM_D-1:0] n_nx_reg, n_ny_reg;
    logic [32:0]      n_d_reg;

    assign ex_num = NUM_D'(e_ex_reg[39] ? -e_ex_reg : e_ex_reg) << FRAC_W;
    assign ey_num = NUM_D'(e_ey_reg[39] ? -e_ey_reg : e_ey_reg) << FRAC_W;
    assign d_lim  = {e_side_reg.d, 32'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_v_reg <= 1'b0;
        else
            n_v_reg <= e_v_reg;
    end

    always_ff @(posedge clk)
    begin
        n_side_reg.p    <= e_side_reg.p;
        n_side_reg.rate <= e_rate_reg;
        n_side_reg.jx   <= e_jx_reg;
        n_side_reg.jy   <= e_jy_reg;
        n_side_reg.ovf  <= 65'(ex_num) >= d_lim;
        n_side_reg.neg  <= e_ex_reg[39];
        n_yside_reg.ovf <= 65'(ey_num) >= d_lim;
        n_yside_reg.neg <= e_ey_reg[39];
        n_nx_reg        <= ex_num;
        n_ny_reg        <= ey_num;
        n_d_reg         <= e_side_reg.d;
    end

    // ---------------- Jacobian derivative dividers ----------------
    logic                   ddx_v, ddy_v;
    logic [JDOT_QUOT_W-1:0] dqx, dqy;
    dside_t                 dx_side;
    yside_t                 dy_side;

    dct_div_pipe #(
        .NUM_W (NUM_D),
        .DEN_W (33),
        .QUOT_W(JDOT_QUOT_W),
        .SIDE_W($bits(dside_t))
    ) u_jdot_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (n_v_reg),
        .num      (n_nx_reg),
        .den      (n_d_reg),
        .in_side  (n_side_reg),
        .out_valid(ddx_v),
        .quot     (dqx),
        .out_side (dx_side)
    );

    dct_div_pipe #(
        .NUM_W (NUM_D),
        .DEN_W (33),
        .QUOT_W(JDOT_QUOT_W),
        .SIDE_W($bits(yside_t))
    ) u_jdot_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (n_v_reg),
        .num      (n_ny_reg),
        .den      (n_d_reg),
        .in_side  (n_yside_reg),
        .out_valid(ddy_v),
        .quot     (dqy),
        .out_side (dy_side)
    );

    // ---------------- stage F: saturation and output register ----------------
    logic signed [31:0] jdx_sat, jdy_sat;
    logic               done_reg;
    dside_t             f_side_reg;
    logic signed [31:0] f_jdx_reg, f_jdy_reg;

    // magnitude q, sign, and q >= 2^32 flag folded into a saturated 32-bit value
    function automatic logic signed [31:0] jd_sat(input logic [31:0] q,
                                                  input logic neg, input logic ovf);
        logic signed [31:0] r;
        if (!neg)
            r = (ovf || q[31]) ? SAT_MAX : $signed(q);
        else if (ovf || (q[31] && (|q[30:0])))
            r = SAT_MIN;
        else
            r = -$signed(q);
        return r;
    endfunction

    assign jdx_sat = jd_sat(dqx, dx_side.neg, dx_side.ovf);
    assign jdy_sat = jd_sat(dqy, dy_side.neg, dy_side.ovf);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ddx_v;
    end

    always_ff @(posedge clk)
    begin
        f_side_reg <= dx_side;
        f_jdx_reg  <= jdx_sat;
        f_jdy_reg  <= jdy_sat;
    end

    // coincident bodies force every derivative term to zero
    assign done             = done_reg;
    assign row_out          = f_side_reg.p.row;
    assign first_column     = f_side_reg.p.col_a;
    assign second_column    = f_side_reg.p.col_b;
    assign constraint_value = f_side_reg.p.value;
    assign coincident       = f_side_reg.p.coin;
    assign constraint_rate  = f_side_reg.p.coin ? '0 : f_side_reg.rate;
    assign jac_x            = f_side_reg.p.coin ? '0 : f_side_reg.jx;
    assign jac_y            = f_side_reg.p.coin ? '0 : f_side_reg.jy;
    assign jacdot_x         = f_side_reg.p.coin ? '0 : f_jdx_reg;
    assign jacdot_y         = f_side_reg.p.coin ? '0 : f_jdy_reg;

    // ---------------- assertions ----------------
    a_jac_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        jdx_v == jdy_v)
        else $error("jacobian divider lanes out of step");

    a_jdot_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        ddx_v == ddy_v)
        else $error("jacobian derivative divider lanes out of step");

    a_jac_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        j_v_reg && !j_side_reg.p.coin |->
            j_jx_reg <= 18'sd65536 && j_jx_reg >= -18'sd65536 &&
            j_jy_reg <= 18'sd65536 && j_jy_reg >= -18'sd65536)
        else $error("jacobian entry outside unit range");

    a_coincident_zero: assert property (@(posedge clk) disable iff (!rst_n)
        p_v_reg && p_side_reg.p.coin |-> p_nx_reg == '0 && p_ny_reg == '0)
        else $error("zero distance with nonzero offset");

endmodule

// ===== hdl/dct_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module dct_div_pipe #(
    parameter int NUM_W  = 49,
    parameter int DEN_W  = 33,
    parameter int QUOT_W = 17,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QUOT_W-1:0] quot,
    output logic [SIDE_W-1:0] out_side
);

    localparam int CW = (NUM_W > DEN_W + QUOT_W) ? NUM_W : DEN_W + QUOT_W;

    logic              v_reg    [QUOT_W];
    logic [CW-1:0]     rem_reg  [QUOT_W];
    logic [DEN_W-1:0]  den_reg  [QUOT_W];
    logic [QUOT_W-1:0] q_reg    [QUOT_W];
    logic [SIDE_W-1:0] side_reg [QUOT_W];

    for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
        logic              v_in;
        logic [CW-1:0]     rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUOT_W-1:0] q_in;
        logic [SIDE_W-1:0] side_in;
        logic [CW-1:0]     sub;
        logic              ge;

        if (j == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = CW'(num);
            assign den_in  = den;
            assign q_in    = '0;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = v_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign den_in  = den_reg[j-1];
            assign q_in    = q_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        assign sub = CW'(den_in) << (QUOT_W - 1 - j);
        assign ge  = (rem_in >= sub);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else
                v_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= ge ? rem_in - sub : rem_in;
            den_reg[j]  <= den_in;
            q_reg[j]    <= {q_in[QUOT_W-2:0], ge};
            side_reg[j] <= side_in;
        end
    end

    assign out_valid = v_reg[QUOT_W-1];
    assign quot      = q_reg[QUOT_W-1];
    assign out_side  = side_reg[QUOT_W-1];

endmodule
